// File: hw/rtl/sprite_rle_line_decoder_macros.svh
// Assertion macros used by the checker file of the sprite decoder.
`ifndef SPRITE_RLE_LINE_DECODER_MACROS_SVH
`define SPRITE_RLE_LINE_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SRLD_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SRLD_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// File: hw/rtl/srld_pkg.sv
// Types and constants shared by the sprite run-length line decoder.
package srld_pkg;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int DIM_W    = 11;
    localparam int PIXADR_W = 20;
    localparam int LIMIT_W  = 2 * DIM_W;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // Decoder mode, one-hot.
    typedef enum logic [3:0] {
        MODE_OPCODE  = 4'b0001,
        MODE_FILL    = 4'b0010,
        MODE_SKIP    = 4'b0100,
        MODE_LITERAL = 4'b1000
    } mode_t;

    // Control state of the decoder that does not depend on the address width.
    typedef struct packed {
        mode_t              mode;
        logic [COUNT_W-1:0] remaining;
        logic [DIM_W-1:0]   row;
    } ctrl_t;

    // One result item.
    typedef struct packed {
        logic [PIXADR_W-1:0] pixel_address;
        logic [COUNT_W-1:0]  span_count;
        logic [BYTE_W-1:0]   pixel_value;
        logic                beyond_image;
        logic                image_done;
    } span_t;

endpackage

// File: hw/rtl/srld_if.sv
// Handshake interfaces of the sprite decoder: byte stream, span results, configuration.
interface srld_stream_if;
    import srld_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface srld_span_if;
    import srld_pkg::*;

    logic                valid;
    logic                ready;
    logic [PIXADR_W-1:0] pixel_address;
    logic [COUNT_W-1:0]  span_count;
    logic [BYTE_W-1:0]   pixel_value;
    logic                beyond_image;
    logic                image_done;

    modport source (
        output valid, output pixel_address, output span_count, output pixel_value,
        output beyond_image, output image_done, input ready
    );
    modport sink (
        input valid, input pixel_address, input span_count, input pixel_value,
        input beyond_image, input image_done, output ready
    );
endinterface

interface srld_cfg_if;
    import srld_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/sprite_rle_line_decoder.sv
// Top level of the sprite run-length line decoder.
//
//  Channel   Direction  Carries
//  stream    in         stream_byte: opcode, fill value, skip count, literal
//  span      out        pixel_address, span_count, pixel_value,
//                       beyond_image, image_done
//  cfg       in         index 0 image_width, index 1 image_height (11 bits)
//
// One stream byte is taken every cycle while the span output is not
// stalled. A byte is held in an input register and decoded from there once
// the output register has room; its span, if any, is then loaded into the
// output register. The decode step is a single pass of short logic on the
// state registers, which sets the unstalled rate of one byte per cycle.
// Reset clears the mode, counts and addresses and sets both image sizes to
// one; no clearing pass is needed. The width-times-height product is
// registered from the size registers. When the span consumer
// stalls with a result waiting, the byte in the input register waits and
// stream ready drops in that same cycle once the input register is occupied.
module sprite_rle_line_decoder #(
    parameter int ADDRESS_BITS = 20
) (
    input  logic  clk,
    input  logic  rst_n,
    srld_stream_if.sink  stream,
    srld_span_if.source  span,
    srld_cfg_if.sink     cfg
);
    import srld_pkg::*;

    // Configuration registers and the image size product derived from them.
    logic [DIM_W-1:0]   image_width_reg;
    logic [DIM_W-1:0]   image_height_reg;
    logic [LIMIT_W-1:0] span_limit_reg;

    // Input register.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Decoder state.
    ctrl_t                   ctrl_reg;
    ctrl_t                   ctrl_next;
    logic [ADDRESS_BITS-1:0] write_address_reg;
    logic [ADDRESS_BITS-1:0] write_address_next;
    logic [ADDRESS_BITS-1:0] row_start_address_reg;
    logic [ADDRESS_BITS-1:0] row_start_address_next;

    // Output register.
    logic  out_valid_reg;
    logic  out_valid_next;
    span_t out_reg;

    logic  result_valid;
    span_t result;
    logic  step_fire;

    // The held byte is decoded when there is room for its possible result.
    assign step_fire    = in_valid_reg && (!out_valid_reg || span.ready);
    assign stream.ready = !in_valid_reg || step_fire;
    assign cfg.ready    = 1'b1;

    srld_decode_step #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_decode_step (
        .stream_byte            (in_byte_reg),
        .image_width            (image_width_reg),
        .image_height           (image_height_reg),
        .span_limit             (span_limit_reg),
        .ctrl                   (ctrl_reg),
        .write_address          (write_address_reg),
        .row_start_address      (row_start_address_reg),
        .ctrl_next              (ctrl_next),
        .write_address_next     (write_address_next),
        .row_start_address_next (row_start_address_next),
        .result_valid           (result_valid),
        .result                 (result)
    );

    always_comb
    begin
        priority if (step_fire)
        begin
            out_valid_next = result_valid;
        end
        else if (span.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg       <= DIM_W'(1);
            image_height_reg      <= DIM_W'(1);
            span_limit_reg        <= LIMIT_W'(1);
            in_valid_reg          <= 1'b0;
            ctrl_reg              <= '{mode: MODE_OPCODE, remaining: '0, row: '0};
            write_address_reg     <= '0;
            row_start_address_reg <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_IMAGE_WIDTH)
                begin
                    image_width_reg <= cfg.data;
                end
                if (cfg.index == CFG_IMAGE_HEIGHT)
                begin
                    image_height_reg <= cfg.data;
                end
            end
            // The product is registered so the span compare starts from a flop.
            span_limit_reg <= LIMIT_W'(image_width_reg) * LIMIT_W'(image_height_reg);

            if (stream.ready)
            begin
                in_valid_reg <= stream.valid;
            end
            if (step_fire)
            begin
                ctrl_reg              <= ctrl_next;
                write_address_reg     <= write_address_next;
                row_start_address_reg <= row_start_address_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_byte_reg <= stream.stream_byte;
        end
        if (step_fire && result_valid)
        begin
            out_reg <= result;
        end
    end

    assign span.valid         = out_valid_reg;
    assign span.pixel_address = out_reg.pixel_address;
    assign span.span_count    = out_reg.span_count;
    assign span.pixel_value   = out_reg.pixel_value;
    assign span.beyond_image  = out_reg.beyond_image;
    assign span.image_done    = out_reg.image_done;

endmodule

// File: hw/rtl/srld_decode_step.sv
// Next-state and result logic of the decoder for one stream byte.
module srld_decode_step #(
    parameter int ADDRESS_BITS = 20
) (
    input  logic [srld_pkg::BYTE_W-1:0]   stream_byte,
    input  logic [srld_pkg::DIM_W-1:0]    image_width,
    input  logic [srld_pkg::DIM_W-1:0]    image_height,
    input  logic [srld_pkg::LIMIT_W-1:0]  span_limit,
    input  srld_pkg::ctrl_t               ctrl,
    input  logic [ADDRESS_BITS-1:0]       write_address,
    input  logic [ADDRESS_BITS-1:0]       row_start_address,
    output srld_pkg::ctrl_t               ctrl_next,
    output logic [ADDRESS_BITS-1:0]       write_address_next,
    output logic [ADDRESS_BITS-1:0]       row_start_address_next,
    output logic                          result_valid,
    output srld_pkg::span_t               result
);
    import srld_pkg::*;

    localparam int CMP_W = (ADDRESS_BITS + 1 > LIMIT_W) ? ADDRESS_BITS + 1 : LIMIT_W;
    localparam int SUM_W = (ADDRESS_BITS > DIM_W) ? ADDRESS_BITS : DIM_W;

    logic [COUNT_W-1:0]      op_count;
    logic [COUNT_W-1:0]      remaining_dec;
    logic                    emit;
    logic [COUNT_W-1:0]      emit_count;
    logic [CMP_W-1:0]        span_end;
    logic [ADDRESS_BITS-1:0] row_advance;
    logic                    last_row;

    assign op_count      = stream_byte[BYTE_W-1:1];
    assign remaining_dec = ctrl.remaining - COUNT_W'(1);

    // The span end is compared unwrapped against width times height.
    assign span_end = CMP_W'(write_address) + CMP_W'(emit_count);
    assign row_advance = ADDRESS_BITS'(SUM_W'(row_start_address) + SUM_W'(image_width));
    assign last_row = ({1'b0, ctrl.row} + (DIM_W + 1)'(1)) >= {1'b0, image_height};

    always_comb
    begin
        ctrl_next              = ctrl;
        write_address_next     = write_address;
        row_start_address_next = row_start_address;
        emit                   = 1'b0;
        emit_count             = ctrl.remaining;
        result_valid           = 1'b0;
        result                 = '0;

        unique case (ctrl.mode)
            MODE_FILL:
            begin
                ctrl_next.mode = MODE_OPCODE;
                emit           = 1'b1;
            end
            MODE_SKIP:
            begin
                ctrl_next.mode     = MODE_OPCODE;
                write_address_next = write_address + ADDRESS_BITS'(stream_byte);
            end
            MODE_LITERAL:
            begin
                ctrl_next.remaining = remaining_dec;
                if (remaining_dec == '0)
                begin
                    ctrl_next.mode = MODE_OPCODE;
                end
                emit       = 1'b1;
                emit_count = COUNT_W'(1);
            end
            MODE_OPCODE:
            begin
                if (!stream_byte[0])
                begin
                    if (op_count != '0)
                    begin
                        ctrl_next.remaining = op_count;
                        ctrl_next.mode      = MODE_FILL;
                    end
                    else if (last_row)
                    begin
                        // Image end: restart at the origin and emit the marker.
                        ctrl_next.row          = '0;
                        ctrl_next.remaining    = '0;
                        row_start_address_next = '0;
                        write_address_next     = '0;
                        result_valid           = 1'b1;
                        result.image_done      = 1'b1;
                    end
                    else
                    begin
                        ctrl_next.row          = ctrl.row + DIM_W'(1);
                        row_start_address_next = row_advance;
                        write_address_next     = row_advance;
                    end
                end
                else if (op_count == '0)
                begin
                    ctrl_next.mode = MODE_SKIP;
                end
                else
                begin
                    ctrl_next.remaining = op_count;
                    ctrl_next.mode      = MODE_LITERAL;
                end
            end
            default:
            begin
                ctrl_next.mode = MODE_OPCODE;
            end
        endcase

        if (emit)
        begin
            result_valid         = 1'b1;
            result.pixel_address = PIXADR_W'(write_address);
            result.span_count    = emit_count;
            result.pixel_value   = stream_byte;
            result.beyond_image  = span_end > CMP_W'(span_limit);
            write_address_next   = ADDRESS_BITS'(span_end);
        end
    end

endmodule

// File: hw/rtl/srld_checker.sv
// Port-level checker of the sprite decoder and its bind to the top level.
`include "sprite_rle_line_decoder_macros.svh"

module srld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        span_valid,
    input logic        span_ready,
    input logic [19:0] pixel_address,
    input logic [6:0]  span_count,
    input logic [7:0]  pixel_value,
    input logic        beyond_image,
    input logic        image_done
);

    // A stalled result stays offered.
    `SRLD_ASSERT_NEXT(a_span_held, span_valid && !span_ready, span_valid, "span dropped while stalled")

    // A stalled result keeps its payload.
    `SRLD_ASSERT_NEXT(a_span_stable, span_valid && !span_ready, $stable(pixel_address) && $stable(span_count) && $stable(pixel_value) && $stable(beyond_image) && $stable(image_done), "span payload changed while stalled")

    // The image end marker carries no span.
    `SRLD_ASSERT_NOW(a_marker_empty, span_valid && image_done, span_count == 7'd0 && pixel_address == 20'd0 && pixel_value == 8'd0 && !beyond_image, "image end marker carries span data")

    // Every fill or literal span covers at least one pixel.
    `SRLD_ASSERT_NOW(a_span_nonzero, span_valid && !image_done, span_count != 7'd0, "pixel span with zero count")

endmodule

bind sprite_rle_line_decoder srld_checker u_srld_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .span_valid    (span.valid),
    .span_ready    (span.ready),
    .pixel_address (span.pixel_address),
    .span_count    (span.span_count),
    .pixel_value   (span.pixel_value),
    .beyond_image  (span.beyond_image),
    .image_done    (span.image_done)
);
